// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PCCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/pcca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_pkg
// shared types and constants of the polygon crossing and area block
// ----------------------------------------------------------------------------
package pcca_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int COORD_W = 16;
  localparam int TOL_W = 16;
  localparam int AREA_W = 39;
  localparam int ACC_W = 41;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic valid;
    vtx_t p;
    vtx_t q;
    vtx_t r;
  } turn_req_t;

  typedef struct packed {
    logic valid;
    logic pos;
    logic neg;
    logic touch;
  } turn_res_t;

  typedef struct packed {
    logic add;
    logic first;
    logic close;
    logic clear;
    vtx_t v;
  } area_cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_AB,
    ST_RD_CD,
    ST_LATCH,
    ST_TURN,
    ST_EVAL,
    ST_CLOSE,
    ST_SUM,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ----- src/pcca_vertex_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_vertex_if
// vertex input channel
// ----------------------------------------------------------------------------
interface pcca_vertex_if;
  logic valid;
  logic ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ----- src/pcca_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_result_if
// result output channel
// ----------------------------------------------------------------------------
interface pcca_result_if;
  logic valid;
  logic ready;
  logic crossed;
  logic [38:0] twice_area;
  logic overflow;

  modport source (output valid, crossed, twice_area, overflow, input ready);
  modport sink (input valid, crossed, twice_area, overflow, output ready);
endinterface

// ----- src/pcca_vertex_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_vertex_ram
// vertex store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pcca_vertex_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pcca_pkg::ADDR_W-1:0] waddr,
  input  pcca_pkg::vtx_t             wdata,
  input  logic [pcca_pkg::ADDR_W-1:0] raddr0,
  input  logic [pcca_pkg::ADDR_W-1:0] raddr1,
  output pcca_pkg::vtx_t             rdata0,
  output pcca_pkg::vtx_t             rdata1
);

  pcca_pkg::vtx_t mem [pcca_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- src/pcca_turn_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_turn_unit
// two-stage cross product with tolerance sign and bounding box touch
// ----------------------------------------------------------------------------
module pcca_turn_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pcca_pkg::TOL_W-1:0] tol,
  input  pcca_pkg::turn_req_t       req,
  output pcca_pkg::turn_res_t       res
);

  logic signed [16:0] ux, uy, vx, vy;
  logic signed [15:0] xlo, xhi, ylo, yhi;
  logic               box;
  logic signed [33:0] p1, p2;
  logic               box1, v1;
  logic signed [34:0] m;
  logic [34:0]        mag;
  logic               zero;

  assign ux = 17'(req.q.x) - 17'(req.p.x);
  assign uy = 17'(req.q.y) - 17'(req.p.y);
  assign vx = 17'(req.r.x) - 17'(req.p.x);
  assign vy = 17'(req.r.y) - 17'(req.p.y);

  assign xlo = (req.p.x < req.q.x) ? req.p.x : req.q.x;
  assign xhi = (req.p.x < req.q.x) ? req.q.x : req.p.x;
  assign ylo = (req.p.y < req.q.y) ? req.p.y : req.q.y;
  assign yhi = (req.p.y < req.q.y) ? req.q.y : req.p.y;
  assign box = (req.r.x >= xlo) && (req.r.x <= xhi) &&
               (req.r.y >= ylo) && (req.r.y <= yhi);

  always_ff @(posedge clk) begin
    p1   <= ux * vy;
    p2   <= vx * uy;
    box1 <= box;
  end

  assign m    = 35'(p1) - 35'(p2);
  assign mag  = m[34] ? 35'(-m) : 35'(m);
  assign zero = (m == '0) || (mag < 35'(tol));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= req.valid;
      res.valid <= v1;
    end
    res.pos   <= !zero && !m[34];
    res.neg   <= !zero && m[34];
    res.touch <= zero && box1;
  end

endmodule

// ----- src/pcca_area_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_area_acc
// shoelace accumulator with closing term, absolute value and saturation
// ----------------------------------------------------------------------------
module pcca_area_acc (
  input  logic                       clk,
  input  logic                       rst,
  input  pcca_pkg::area_cmd_t        cmd,
  output logic [pcca_pkg::AREA_W-1:0] mag
);

  pcca_pkg::vtx_t                    prev, first;
  logic signed [31:0]                p1, p2;
  logic                              pv;
  logic signed [pcca_pkg::ACC_W-1:0] acc;
  logic [pcca_pkg::ACC_W-1:0]        abs_acc;

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      prev <= cmd.v;
      if (cmd.first) begin
        first <= cmd.v;
      end
      p1 <= prev.x * cmd.v.y;
      p2 <= cmd.v.x * prev.y;
    end else if (cmd.close) begin
      p1 <= prev.x * first.y;
      p2 <= first.x * prev.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pv  <= 1'b0;
      acc <= '0;
    end else begin
      pv <= (cmd.add && !cmd.first) || cmd.close;
      if (pv) begin
        acc <= acc + pcca_pkg::ACC_W'(p1) - pcca_pkg::ACC_W'(p2);
      end
    end
  end

  assign abs_acc = acc[pcca_pkg::ACC_W-1] ? pcca_pkg::ACC_W'(-acc) : pcca_pkg::ACC_W'(acc);
  assign mag = (abs_acc[pcca_pkg::ACC_W-1:pcca_pkg::AREA_W] != '0) ? '1
             : abs_acc[pcca_pkg::AREA_W-1:0];

endmodule

// ----- src/polygon_cross_check_and_area.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_cross_check_and_area
// polygon self-crossing check and twice-area unit
// ----------------------------------------------------------------------------
// Vertices load one per cycle into a dual-read vertex memory while the
// shoelace sum accumulates. The item marked last starts, when four or more
// vertices are stored, a sweep over every pair of non-adjacent edges; each
// pair passes two memory read states, a latch state, a turn state that
// issues four cross products through the two-stage turn unit and drains it,
// and an evaluate state, and the sweep stops at the first crossing.
// One polygon is in work at a time; the next vertex is taken after the
// result transfer. Vertices past 256 are dropped and flagged as overflow.
module polygon_cross_check_and_area (
  input  logic                      clk,
  input  logic                      rst,
  pcca_vertex_if.sink               vertex,
  pcca_result_if.source             result,
  input  logic                      cfg_we,
  input  logic [pcca_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int CW = pcca_pkg::CNT_W;
  localparam int AW = pcca_pkg::ADDR_W;

  pcca_pkg::state_t  state, state_next;
  logic [pcca_pkg::TOL_W-1:0] tol;
  logic [CW-1:0]     count, cnt_after, i_idx, j_idx, i1, j1, jn, i3;
  logic              ovf, crossed;
  logic              accept, store, pair_ok, hit;
  logic [2:0]        kiss;
  logic [1:0]        rcnt;
  logic [3:0]        pos, neg;
  logic              touch;
  pcca_pkg::vtx_t    va, vb, vc, vd, rd0, rd1;
  logic [AW-1:0]     ra0, ra1;
  pcca_pkg::turn_req_t req;
  pcca_pkg::turn_res_t res;
  pcca_pkg::area_cmd_t acmd;
  logic [pcca_pkg::AREA_W-1:0] mag;
  logic              out_crossed, out_ovf;
  logic [pcca_pkg::AREA_W-1:0] out_area;

  assign accept    = vertex.valid && vertex.ready;
  assign store     = accept && (count < CW'(pcca_pkg::MAX_VERTICES));
  assign cnt_after = store ? count + 1'b1 : count;
  assign i1        = (i_idx + 1'b1 == count) ? '0 : i_idx + 1'b1;
  assign j1        = (j_idx + 1'b1 == count) ? '0 : j_idx + 1'b1;
  assign jn        = j_idx + 1'b1;
  assign i3        = i_idx + CW'(3);
  assign pair_ok   = (jn < count) && !((i_idx == '0) && (jn == count - 1'b1));
  assign hit       = (((pos[0] & neg[1]) | (neg[0] & pos[1])) &
                      ((pos[2] & neg[3]) | (neg[2] & pos[3]))) | touch;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pcca_pkg::ST_LOAD: begin
        if (accept && vertex.last_vertex) begin
          state_next = (cnt_after >= CW'(4)) ? pcca_pkg::ST_RD_AB : pcca_pkg::ST_CLOSE;
        end
      end
      pcca_pkg::ST_RD_AB: state_next = pcca_pkg::ST_RD_CD;
      pcca_pkg::ST_RD_CD: state_next = pcca_pkg::ST_LATCH;
      pcca_pkg::ST_LATCH: state_next = pcca_pkg::ST_TURN;
      pcca_pkg::ST_TURN: begin
        if (res.valid && rcnt == 2'd3) begin
          state_next = pcca_pkg::ST_EVAL;
        end
      end
      pcca_pkg::ST_EVAL: begin
        if (hit) begin
          state_next = pcca_pkg::ST_FIN;
        end else if (pair_ok || i3 < count) begin
          state_next = pcca_pkg::ST_RD_AB;
        end else begin
          state_next = pcca_pkg::ST_CLOSE;
        end
      end
      pcca_pkg::ST_CLOSE: state_next = pcca_pkg::ST_SUM;
      pcca_pkg::ST_SUM:   state_next = pcca_pkg::ST_FIN;
      pcca_pkg::ST_FIN:   state_next = pcca_pkg::ST_OUT;
      pcca_pkg::ST_OUT: begin
        if (result.ready) begin
          state_next = pcca_pkg::ST_LOAD;
        end
      end
      default: state_next = pcca_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    vertex.ready = (state == pcca_pkg::ST_LOAD);
    result.valid = (state == pcca_pkg::ST_OUT);
    ra0 = i_idx[AW-1:0];
    ra1 = i1[AW-1:0];
    if (state == pcca_pkg::ST_RD_CD) begin
      ra0 = j_idx[AW-1:0];
      ra1 = j1[AW-1:0];
    end
    req.valid = (state == pcca_pkg::ST_TURN) && (kiss < 3'd4);
    unique case (kiss[1:0])
      2'd0: begin req.p = va; req.q = vb; req.r = vc; end
      2'd1: begin req.p = va; req.q = vb; req.r = vd; end
      2'd2: begin req.p = vc; req.q = vd; req.r = va; end
      2'd3: begin req.p = vc; req.q = vd; req.r = vb; end
      default: begin req.p = va; req.q = vb; req.r = vc; end
    endcase
    acmd.add   = store;
    acmd.first = (count == '0);
    acmd.close = (state == pcca_pkg::ST_CLOSE);
    acmd.clear = (state == pcca_pkg::ST_OUT) && result.ready;
    acmd.v.x   = vertex.vertex_x;
    acmd.v.y   = vertex.vertex_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pcca_pkg::ST_LOAD;
      tol     <= '0;
      count   <= '0;
      ovf     <= 1'b0;
      crossed <= 1'b0;
      i_idx   <= '0;
      j_idx   <= '0;
      kiss    <= '0;
      rcnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (accept) begin
        count <= cnt_after;
        if (!store) begin
          ovf <= 1'b1;
        end
        i_idx <= '0;
        j_idx <= CW'(2);
      end
      if (state == pcca_pkg::ST_LATCH) begin
        kiss <= '0;
        rcnt <= '0;
      end
      if (req.valid) begin
        kiss <= kiss + 1'b1;
      end
      if (state == pcca_pkg::ST_TURN && res.valid) begin
        rcnt <= rcnt + 1'b1;
      end
      if (state == pcca_pkg::ST_EVAL) begin
        if (hit) begin
          crossed <= 1'b1;
        end else if (pair_ok) begin
          j_idx <= jn;
        end else begin
          i_idx <= i_idx + 1'b1;
          j_idx <= i3;
        end
      end
      if (acmd.clear) begin
        count   <= '0;
        ovf     <= 1'b0;
        crossed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcca_pkg::ST_RD_CD) begin
      va <= rd0;
      vb <= rd1;
    end
    if (state == pcca_pkg::ST_LATCH) begin
      vc    <= rd0;
      vd    <= rd1;
      touch <= 1'b0;
    end
    if (state == pcca_pkg::ST_TURN && res.valid) begin
      pos[rcnt] <= res.pos;
      neg[rcnt] <= res.neg;
      if (res.touch) begin
        touch <= 1'b1;
      end
    end
    if (state == pcca_pkg::ST_FIN) begin
      out_crossed <= crossed;
      out_area    <= crossed ? '0 : mag;
      out_ovf     <= ovf;
    end
  end

  assign result.crossed    = out_crossed;
  assign result.twice_area = out_area;
  assign result.overflow   = out_ovf;

  pcca_vertex_ram u_ram (
    .clk    (clk),
    .we     (store),
    .waddr  (count[AW-1:0]),
    .wdata  (acmd.v),
    .raddr0 (ra0),
    .raddr1 (ra1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  pcca_turn_unit u_turn (
    .clk (clk),
    .rst (rst),
    .tol (tol),
    .req (req),
    .res (res)
  );

  pcca_area_acc u_area (
    .clk (clk),
    .rst (rst),
    .cmd (acmd),
    .mag (mag)
  );

endmodule

// ----- src/pcca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcca_checker
// port-level checks of the polygon crossing and area block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcca_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_crossed,
  input logic [38:0] out_area
);

  `PCCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PCCA_ASSERT_SAME(a_crossed_zero, out_valid && out_crossed, out_area == '0)
  `PCCA_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready)
  `PCCA_ASSERT_SAME(a_no_load_with_result, out_valid, !in_ready)

endmodule

bind polygon_cross_check_and_area pcca_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (vertex.valid),
  .in_ready    (vertex.ready),
  .in_last     (vertex.last_vertex),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_crossed (result.crossed),
  .out_area    (result.twice_area)
);

// ----- test/polygon_cross_check_and_area_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_cross_check_and_area_test
// self-checking bench for the polygon crossing and area block: directed
// polygons (some with results from the table), an overflow case, then random
// polygons, others checked by a behavioral predictor of the crossing sweep and shoelace sum
// ----------------------------------------------------------------------------
module polygon_cross_check_and_area_test;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit last;
    bit known;
    bit crossed;
    logic [38:0] area;
    bit ovf;
  } vertex_row_t;

  typedef struct {
    bit crossed;
    logic [38:0] area;
    bit ovf;
  } polygon_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [pcca_pkg::TOL_W-1:0] cfg_wdata = '0;

  pcca_vertex_if vertex_ch ();
  pcca_result_if result_ch ();

  polygon_cross_check_and_area dut (
    .clk(clk), .rst(rst), .vertex(vertex_ch.sink), .result(result_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  longint tol_q;
  longint px[$];
  longint py[$];
  bit ovf_q;
  polygon_result_t pending_results[$];
  int errors = 0;
  bit calm = 0;
  longint cycles = 0;

  function automatic longint turn_of(int p, int q, int r);
    return (px[q] - px[p]) * (py[r] - py[p]) - (px[r] - px[p]) * (py[q] - py[p]);
  endfunction

  function automatic int sign_of(longint m);
    longint mag;
    mag = m < 0 ? -m : m;
    if (m == 0 || mag < tol_q) return 0;
    return m > 0 ? 1 : -1;
  endfunction

  function automatic bit in_box(int p, int q, int r);
    longint xlo, xhi, ylo, yhi;
    xlo = px[p] < px[q] ? px[p] : px[q];
    xhi = px[p] < px[q] ? px[q] : px[p];
    ylo = py[p] < py[q] ? py[p] : py[q];
    yhi = py[p] < py[q] ? py[q] : py[p];
    return px[r] >= xlo && px[r] <= xhi && py[r] >= ylo && py[r] <= yhi;
  endfunction

  function automatic bit edges_meet(int a, int b, int c, int d);
    int s1, s2, s3, s4;
    s1 = sign_of(turn_of(a, b, c));
    s2 = sign_of(turn_of(a, b, d));
    s3 = sign_of(turn_of(c, d, a));
    s4 = sign_of(turn_of(c, d, b));
    if (s1 * s2 < 0 && s3 * s4 < 0) return 1;
    if (s1 == 0 && in_box(a, b, c)) return 1;
    if (s2 == 0 && in_box(a, b, d)) return 1;
    if (s3 == 0 && in_box(c, d, a)) return 1;
    if (s4 == 0 && in_box(c, d, b)) return 1;
    return 0;
  endfunction

  // returns 1 when the vertex closes a polygon and fills res
  function automatic bit predict_polygon(longint x, longint y, bit last,
                                         output polygon_result_t res);
    int n;
    longint s;
    res = '{0, '0, 0};
    if (px.size() < pcca_pkg::MAX_VERTICES) begin
      px = {px, x};
      py = {py, y};
    end else begin
      ovf_q = 1;
    end
    if (!last) return 0;
    n = px.size();
    for (int i = 0; i < n && !res.crossed; i++)
      for (int j = i + 2; j < n && !res.crossed; j++)
        if (!(i == 0 && j == n - 1))
          res.crossed = edges_meet(i, (i + 1) % n, j, (j + 1) % n);
    if (!res.crossed && n > 0) begin
      s = 0;
      for (int k = 0; k < n; k++)
        s += px[k] * py[(k + 1) % n] - px[(k + 1) % n] * py[k];
      if (s < 0) s = -s;
      res.area = (s > 64'h7F_FFFF_FFFF) ? 39'h7F_FFFF_FFFF : s[38:0];
    end
    res.ovf = ovf_q;
    px.delete();
    py.delete();
    ovf_q = 0;
    return 1;
  endfunction

  vertex_row_t directed_rows[$];

  function automatic void add_row(int x, int y, bit last, bit known = 0,
                                  bit cr = 0, logic [38:0] ar = 0, bit ov = 0);
    vertex_row_t r;
    r.x = 16'(x); r.y = 16'(y); r.last = last; r.known = known;
    r.crossed = cr; r.area = ar; r.ovf = ov;
    directed_rows = {directed_rows, r};
  endfunction

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
    polygon_result_t res;
    while (!calm && $urandom_range(99) < 7) begin
      vertex_ch.valid <= 0;
      @(negedge clk);
    end
    vertex_ch.valid <= 1;
    vertex_ch.vertex_x <= x;
    vertex_ch.vertex_y <= y;
    vertex_ch.last_vertex <= last;
    @(posedge clk);
    while (!vertex_ch.ready) @(posedge clk);
    if (predict_polygon(x, y, last, res)) pending_results = {pending_results, res};
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    vertex_ch.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    tol_q = v;
  endtask

  task automatic send_random_polygon(int n, int span);
    int cx, cy;
    cx = $urandom_range(65535) - 32768;
    cy = $urandom_range(65535) - 32768;
    for (int k = 0; k < n; k++) begin
      int x, y;
      if (span == 0) begin
        x = $urandom_range(65535) - 32768;
        y = $urandom_range(65535) - 32768;
      end else begin
        x = cx + int'($urandom_range(2 * span)) - span;
        y = cy + int'($urandom_range(2 * span)) - span;
      end
      send_vertex(x[15:0], y[15:0], k == n - 1);
    end
  endtask

  task automatic send_convex_polygon(int n);
    int r, cx, cy;
    real a;
    r = $urandom_range(20000, 3);
    cx = $urandom_range(2000) - 1000;
    cy = $urandom_range(2000) - 1000;
    for (int k = 0; k < n; k++) begin
      int x, y;
      a = 6.2831853 * k / n;
      x = cx + $rtoi(r * $cos(a));
      y = cy + $rtoi(r * $sin(a));
      send_vertex(x[15:0], y[15:0], k == n - 1);
    end
  endtask

  // result side
  always @(negedge clk) begin
    if (rst) result_ch.ready <= 0;
    else result_ch.ready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        polygon_result_t e;
        e = pending_results.pop_front();
        if (result_ch.crossed !== e.crossed) begin
          $error("crossed exp %0d got %0d", e.crossed, result_ch.crossed); errors++;
        end
        if (result_ch.twice_area !== e.area) begin
          $error("twice_area exp %0d got %0d", e.area, result_ch.twice_area); errors++;
        end
        if (result_ch.overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, result_ch.overflow); errors++;
        end
      end
    end
    if (cycles > 4000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int sent;
    vertex_ch.valid = 0;
    vertex_ch.vertex_x = 0;
    vertex_ch.vertex_y = 0;
    vertex_ch.last_vertex = 0;
    result_ch.ready = 0;
    tol_q = 0;
    ovf_q = 0;
    // single vertex, area zero
    add_row(-32768, 32767, 1, 1, 0, 0, 0);
    // square at the extremes: twice area 65535*65535*2
    add_row(-32768, -32768, 0);
    add_row(32767, -32768, 0);
    add_row(32767, 32767, 0);
    add_row(-32768, 32767, 1, 1, 0, 39'd8589672450, 0);
    // bow tie crosses
    add_row(0, 0, 0);
    add_row(16, 16, 0);
    add_row(16, 0, 0);
    add_row(0, 16, 1, 1, 1, 0, 0);
    // triangle, two vertices
    add_row(0, 0, 0); add_row(32, 0, 0); add_row(0, 32, 1);
    add_row(5, 5, 0); add_row(-7, 9, 1, 1, 0, 0, 0);
    // collinear touch: vertex lies on a far edge
    add_row(0, 0, 0); add_row(32, 0, 0); add_row(16, 0, 0); add_row(16, 16, 1);
    // all-equal points, exact zero cross products
    add_row(3, 3, 0); add_row(3, 3, 0); add_row(3, 3, 0); add_row(3, 3, 1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last);
      if (directed_rows[i].known) begin
        pending_results[pending_results.size() - 1].crossed = directed_rows[i].crossed;
        pending_results[pending_results.size() - 1].area = directed_rows[i].area;
        pending_results[pending_results.size() - 1].ovf = directed_rows[i].ovf;
      end
    end
    // overflow: 258 vertices on a zigzag, crossing stops the sweep early
    write_tolerance(16'hFFFF);
    for (int k = 0; k < 258; k++)
      send_vertex(16'(k * 3), 16'((k % 2) * 5), k == 257);
    sent = 0;
    calm = 1;
    for (int p = 0; p < 8; p++) send_random_polygon($urandom_range(8, 4), 40);
    calm = 0;
    while (sent < 220) begin
      int n, kind;
      if (sent % 120 == 0) begin
        case ($urandom_range(3))
          0: write_tolerance(16'd0);
          1: write_tolerance(16'hFFFF);
          default: write_tolerance(16'($urandom_range(2000)));
        endcase
      end
      n = $urandom_range(12, 1);
      kind = $urandom_range(9);
      if (kind < 5) send_convex_polygon(n < 3 ? 3 : n);
      else if (kind < 8) send_random_polygon(n, $urandom_range(64, 1));
      else send_random_polygon(n, 0);
      sent += n;
    end
    vertex_ch.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/pcca_pkg.sv
src/pcca_vertex_if.sv
src/pcca_result_if.sv
src/pcca_vertex_ram.sv
src/pcca_turn_unit.sv
src/pcca_area_acc.sv
src/polygon_cross_check_and_area.sv
src/pcca_checker.sv
test/polygon_cross_check_and_area_test.sv
